// File: hw/rtl/deq_pkg.sv
// Shared constants, codes and control types of the double-ended queue.
`timescale 1ns / 1ps

package deq_pkg;

  localparam int DEPTH  = 16;
  localparam int IDX_W  = $clog2(DEPTH);
  localparam int CNT_W  = $clog2(DEPTH + 1);
  localparam int SUM_W  = CNT_W + 1;
  localparam int DATA_W = 32;
  localparam int MODE_W = 3;
  localparam int STAT_W = 2;

  typedef enum logic [MODE_W-1:0] {
    MODE_PUSH_FRONT = 3'd0,
    MODE_PUSH_BACK  = 3'd1,
    MODE_POP_FRONT  = 3'd2,
    MODE_POP_BACK   = 3'd3,
    MODE_PEEK_FRONT = 3'd4,
    MODE_PEEK_BACK  = 3'd5
  } mode_e;

  typedef enum logic [STAT_W-1:0] {
    STATUS_DONE  = 2'd0,
    STATUS_EMPTY = 2'd1,
    STATUS_FULL  = 2'd2
  } status_e;

  typedef struct packed {
    logic    load;
    logic    wr;
    logic    rd;
    logic    take;
    logic    at_front;
    status_e status;
  } dp_cmd_t;

  typedef struct packed {
    logic empty;
    logic full;
  } dp_status_t;

endpackage

// File: hw/rtl/deq_if.sv
// Request and response channel interfaces of the double-ended queue.
`timescale 1ns / 1ps

interface deq_req_if;
  logic                                valid;
  logic                                ready;
  logic [deq_pkg::MODE_W-1:0]          mode;
  logic signed [deq_pkg::DATA_W-1:0]   value;

  modport source (output valid, output mode, output value, input ready);
  modport sink (input valid, input mode, input value, output ready);
endinterface

interface deq_rsp_if;
  logic                                valid;
  logic                                ready;
  logic signed [deq_pkg::DATA_W-1:0]   result_value;
  logic [deq_pkg::STAT_W-1:0]          status;
  logic [deq_pkg::CNT_W-1:0]           occupancy;

  modport source (output valid, output result_value, output status, output occupancy,
                  input ready);
  modport sink (input valid, input result_value, input status, input occupancy,
                output ready);
endinterface

// File: hw/rtl/deq_ctrl.sv
// Controller of the double-ended queue: handshakes and operation decode.
`timescale 1ns / 1ps

module deq_ctrl (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       req_valid_i,
  output logic                       req_ready_o,
  input  logic [deq_pkg::MODE_W-1:0] req_mode_i,
  output logic                       rsp_valid_o,
  input  logic                       rsp_ready_i,
  input  deq_pkg::dp_status_t        dp_status_i,
  output deq_pkg::dp_cmd_t           dp_cmd_o
);
  import deq_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_RESP = 2'b10
  } state_e;

  state_e state_q, state_d;
  logic   accept;

  assign req_ready_o = (state_q == S_IDLE);
  assign rsp_valid_o = (state_q == S_RESP);
  assign accept      = req_valid_i && req_ready_o;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (accept) state_d = S_RESP;
      end
      S_RESP: begin
        if (rsp_ready_i) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    dp_cmd_o          = '0;
    dp_cmd_o.load     = accept;
    dp_cmd_o.status   = STATUS_DONE;
    unique case (mode_e'(req_mode_i))
      MODE_PUSH_FRONT, MODE_PUSH_BACK: begin
        dp_cmd_o.at_front = (mode_e'(req_mode_i) == MODE_PUSH_FRONT);
        if (dp_status_i.full) begin
          dp_cmd_o.status = STATUS_FULL;
        end else begin
          dp_cmd_o.wr = 1'b1;
        end
      end
      MODE_POP_FRONT, MODE_POP_BACK, MODE_PEEK_FRONT, MODE_PEEK_BACK: begin
        dp_cmd_o.at_front = (mode_e'(req_mode_i) == MODE_POP_FRONT) ||
                            (mode_e'(req_mode_i) == MODE_PEEK_FRONT);
        if (dp_status_i.empty) begin
          dp_cmd_o.status = STATUS_EMPTY;
        end else begin
          dp_cmd_o.rd   = 1'b1;
          dp_cmd_o.take = (mode_e'(req_mode_i) == MODE_POP_FRONT) ||
                          (mode_e'(req_mode_i) == MODE_POP_BACK);
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// File: hw/rtl/deq_datapath.sv
// Datapath of the double-ended queue: ring store, front index, count and result registers.
`timescale 1ns / 1ps

module deq_datapath (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  deq_pkg::dp_cmd_t                  dp_cmd_i,
  output deq_pkg::dp_status_t               dp_status_o,
  input  logic signed [deq_pkg::DATA_W-1:0] value_i,
  output logic signed [deq_pkg::DATA_W-1:0] result_value_o,
  output logic [deq_pkg::STAT_W-1:0]        status_o,
  output logic [deq_pkg::CNT_W-1:0]         occupancy_o
);
  import deq_pkg::*;

  logic [DATA_W-1:0] mem [DEPTH];

  logic [IDX_W-1:0]  front_q;
  logic [CNT_W-1:0]  count_q;
  status_e           status_q;
  logic              hit_q;
  logic [DATA_W-1:0] rd_data_q;

  logic [SUM_W-1:0]  back_raw, tail_raw;
  logic [IDX_W-1:0]  back_pos, tail_pos, front_dec, front_inc, wr_addr, rd_addr;

  always_comb begin
    back_raw  = SUM_W'(front_q) + SUM_W'(count_q);
    tail_raw  = back_raw - SUM_W'(1);
    back_pos  = (back_raw >= SUM_W'(DEPTH)) ? IDX_W'(back_raw - SUM_W'(DEPTH))
                                            : IDX_W'(back_raw);
    tail_pos  = (tail_raw >= SUM_W'(DEPTH)) ? IDX_W'(tail_raw - SUM_W'(DEPTH))
                                            : IDX_W'(tail_raw);
    front_dec = (front_q == '0) ? IDX_W'(DEPTH - 1) : front_q - IDX_W'(1);
    front_inc = (front_q == IDX_W'(DEPTH - 1)) ? '0 : front_q + IDX_W'(1);
    wr_addr   = dp_cmd_i.at_front ? front_dec : back_pos;
    rd_addr   = dp_cmd_i.at_front ? front_q : tail_pos;
  end

  assign dp_status_o.empty = (count_q == '0);
  assign dp_status_o.full  = (count_q == CNT_W'(DEPTH));

  always_ff @(posedge clk_i) begin
    if (dp_cmd_i.load && dp_cmd_i.wr) begin
      mem[wr_addr] <= value_i;
    end
    if (dp_cmd_i.load && dp_cmd_i.rd) begin
      rd_data_q <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      front_q  <= '0;
      count_q  <= '0;
      status_q <= STATUS_DONE;
      hit_q    <= 1'b0;
    end else if (dp_cmd_i.load) begin
      status_q <= dp_cmd_i.status;
      hit_q    <= dp_cmd_i.rd;
      if (dp_cmd_i.wr) begin
        count_q <= count_q + CNT_W'(1);
        if (dp_cmd_i.at_front) front_q <= front_dec;
      end else if (dp_cmd_i.rd && dp_cmd_i.take) begin
        count_q <= count_q - CNT_W'(1);
        if (dp_cmd_i.at_front) front_q <= front_inc;
      end
    end
  end

  assign result_value_o = hit_q ? rd_data_q : '0;
  assign status_o       = status_q;
  assign occupancy_o    = count_q;

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(DEPTH))
    else $error("Element count exceeds the queue depth.");

  a_push_grows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    dp_cmd_i.load && dp_cmd_i.wr |=> count_q == $past(count_q) + CNT_W'(1))
    else $error("A successful push did not grow the count by one.");

  a_back_pop_front: assert property (@(posedge clk_i) disable iff (!rst_ni)
    dp_cmd_i.load && dp_cmd_i.rd && !dp_cmd_i.at_front |=> $stable(front_q))
    else $error("A back-end read moved the front index.");

  a_failed_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    dp_cmd_i.load && dp_cmd_i.status != STATUS_DONE |=> $stable(count_q) && $stable(front_q))
    else $error("A rejected transaction changed the queue.");

endmodule

// File: hw/rtl/double_ended_queue.sv
// Top level of the double-ended queue: channel wiring of controller and datapath.
//
// A bounded deque of 16 signed 32-bit elements held in a ring. Each request
// transaction on req_i carries a mode (push front, push back, pop front, pop
// back, peek front, peek back) and a value used by pushes. Every request
// produces exactly one response transaction on rsp_o with the removed or
// peeked value, a status (done, empty, full) and the occupancy afterwards.
// Pops and peeks on an empty queue, and pushes on a full one, report the
// condition, return zero and leave the queue untouched.
// A request is taken and its response is valid from the next cycle; the
// ring store is read on the accepting edge into a registered read port.
// One request is in flight at a time, so req_i.ready stays low until the
// response of the last request has been taken.
// While rsp_o.ready is low the response holds and req_i.ready stays low.
// Reset empties the queue at once: front index and count return to zero
// and no response is pending; the store contents need no clearing.
`timescale 1ns / 1ps

module double_ended_queue (
  input  logic      clk_i,
  input  logic      rst_ni,
  deq_req_if.sink   req_i,
  deq_rsp_if.source rsp_o
);
  import deq_pkg::*;

  dp_cmd_t    dp_cmd;
  dp_status_t dp_status;

  deq_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (req_i.valid),
    .req_ready_o (req_i.ready),
    .req_mode_i  (req_i.mode),
    .rsp_valid_o (rsp_o.valid),
    .rsp_ready_i (rsp_o.ready),
    .dp_status_i (dp_status),
    .dp_cmd_o    (dp_cmd)
  );

  deq_datapath u_datapath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .dp_cmd_i       (dp_cmd),
    .dp_status_o    (dp_status),
    .value_i        (req_i.value),
    .result_value_o (rsp_o.result_value),
    .status_o       (rsp_o.status),
    .occupancy_o    (rsp_o.occupancy)
  );

endmodule

// File: tb/sv/double_ended_queue_test.sv
// Self-checking testbench of the double-ended queue with a shadow deque that predicts every response.
`timescale 1ns / 1ps

module double_ended_queue_test;
  import deq_pkg::*;

  localparam logic [MODE_W-1:0] MODE_SPARE_6 = 3'd6;
  localparam logic [MODE_W-1:0] MODE_SPARE_7 = 3'd7;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int SETTLE_CYCLES = 10;
  localparam int ITEMS_PER_PHASE = 400;

  typedef struct {
    logic signed [DATA_W-1:0] result_value;
    logic [STAT_W-1:0]        status;
    logic [CNT_W-1:0]         occupancy;
  } deque_outcome_t;

  class deque_shadow;
    logic [DATA_W-1:0] ring [DEPTH];
    logic [IDX_W-1:0]  head;
    logic [CNT_W-1:0]  count;
    deque_outcome_t    pending_results [$];
    int                mismatches;

    function new();
      head = '0;
      count = '0;
      mismatches = 0;
    endfunction

    task report_mismatch(string what);
      $display("mismatch at %0t: %s", $realtime, what);
      mismatches++;
    endtask

    function void accept_request(logic [MODE_W-1:0] mode, logic [DATA_W-1:0] value);
      deque_outcome_t   outcome;
      logic [IDX_W-1:0] slot;
      outcome.result_value = '0;
      outcome.status = STATUS_DONE;
      case (mode)
        MODE_PUSH_FRONT, MODE_PUSH_BACK: begin
          if (count == DEPTH) begin
            outcome.status = STATUS_FULL;
          end else if (mode == MODE_PUSH_FRONT) begin
            head = (head == '0) ? IDX_W'(DEPTH - 1) : head - IDX_W'(1);
            ring[head] = value;
            count++;
          end else begin
            slot = IDX_W'((int'(head) + int'(count)) % DEPTH);
            ring[slot] = value;
            count++;
          end
        end
        MODE_POP_FRONT, MODE_PEEK_FRONT: begin
          if (count == 0) begin
            outcome.status = STATUS_EMPTY;
          end else begin
            outcome.result_value = ring[head];
            if (mode == MODE_POP_FRONT) begin
              head = (head == IDX_W'(DEPTH - 1)) ? '0 : head + IDX_W'(1);
              count--;
            end
          end
        end
        MODE_POP_BACK, MODE_PEEK_BACK: begin
          if (count == 0) begin
            outcome.status = STATUS_EMPTY;
          end else begin
            slot = IDX_W'((int'(head) + int'(count) - 1) % DEPTH);
            outcome.result_value = ring[slot];
            if (mode == MODE_POP_BACK) count--;
          end
        end
        default: begin
        end
      endcase
      outcome.occupancy = count;
      pending_results.push_back(outcome);
    endfunction

    task match_response(logic signed [DATA_W-1:0] result_value,
                        logic [STAT_W-1:0] status, logic [CNT_W-1:0] occupancy);
      deque_outcome_t awaited;
      if (pending_results.size() == 0) begin
        report_mismatch("response transaction with no request outstanding");
        return;
      end
      awaited = pending_results.pop_front();
      if (result_value !== awaited.result_value)
        report_mismatch($sformatf("result_value %0d, expected %0d", result_value,
                                  awaited.result_value));
      if (status !== awaited.status)
        report_mismatch($sformatf("status %0d, expected %0d", status, awaited.status));
      if (occupancy !== awaited.occupancy)
        report_mismatch($sformatf("occupancy %0d, expected %0d", occupancy,
                                  awaited.occupancy));
    endtask

    function int outstanding();
      return pending_results.size();
    endfunction
  endclass

  logic clk_i;
  logic rst_ni;
  deq_req_if req ();
  deq_rsp_if rsp ();

  deque_shadow shadow;
  int send_idle_pct;
  int recv_stall_pct;
  int hold_request;

  double_ended_queue uut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req),
    .rsp_o  (rsp)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  task automatic send_request(input logic [MODE_W-1:0] mode, input logic [DATA_W-1:0] value);
    while ($urandom_range(99) < send_idle_pct) begin
      @(negedge clk_i);
      req.valid <= 1'b0;
    end
    @(negedge clk_i);
    req.valid <= 1'b1;
    req.mode  <= mode;
    req.value <= value;
    @(posedge clk_i);
    while (req.ready !== 1'b1) @(posedge clk_i);
    shadow.accept_request(mode, value);
  endtask

  task automatic wait_drained();
    while (shadow.outstanding() != 0) @(posedge clk_i);
  endtask

  task automatic run_random(input int items);
    int               run_left;
    int               push_pct;
    logic [MODE_W-1:0] mode;
    logic [DATA_W-1:0] value;
    run_left = 0;
    push_pct = 50;
    for (int n = 0; n < items; n++) begin
      if (run_left == 0) begin
        run_left = $urandom_range(4, 40);
        case ($urandom_range(2))
          0: push_pct = 80;
          1: push_pct = 20;
          default: push_pct = 50;
        endcase
      end
      run_left--;
      if ($urandom_range(99) < 3) begin
        mode = $urandom_range(1) ? MODE_SPARE_6 : MODE_SPARE_7;
      end else if ($urandom_range(99) < push_pct) begin
        mode = $urandom_range(1) ? MODE_PUSH_BACK : MODE_PUSH_FRONT;
      end else begin
        case ($urandom_range(3))
          0: mode = MODE_POP_FRONT;
          1: mode = MODE_POP_BACK;
          2: mode = MODE_PEEK_FRONT;
          default: mode = MODE_PEEK_BACK;
        endcase
      end
      case ($urandom_range(9))
        0: value = 32'h8000_0000;
        1: value = 32'h7fff_ffff;
        2: value = 32'h0000_0000;
        3: value = 32'hffff_ffff;
        default: value = $urandom;
      endcase
      send_request(mode, value);
    end
  endtask

  initial begin
    int held;
    held = 0;
    forever begin
      @(negedge clk_i);
      if (hold_request > 0) begin
        held = hold_request;
        hold_request = 0;
      end
      if (held > 0) begin
        rsp.ready <= 1'b0;
        held--;
      end else begin
        rsp.ready <= ($urandom_range(99) >= recv_stall_pct);
      end
      @(posedge clk_i);
      if (rsp.valid === 1'b1 && rsp.ready === 1'b1)
        shadow.match_response(rsp.result_value, rsp.status, rsp.occupancy);
    end
  end

  initial begin
    int quiet;
    quiet = 0;
    while (quiet < WATCHDOG_LIMIT) begin
      @(posedge clk_i);
      if ((req.valid === 1'b1 && req.ready === 1'b1) ||
          (rsp.valid === 1'b1 && rsp.ready === 1'b1))
        quiet = 0;
      else
        quiet++;
    end
    $display("tb: failure");
    $finish;
  end

  initial begin
    shadow = new();
    send_idle_pct = 0;
    recv_stall_pct = 0;
    hold_request = 0;
    rst_ni = 1'b0;
    req.valid = 1'b0;
    req.mode = '0;
    req.value = '0;
    rsp.ready = 1'b0;
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Empty queue errors, spare modes, and single element pops from either end.
    send_request(MODE_POP_FRONT, 32'h1234_5678);
    send_request(MODE_POP_BACK, 32'hffff_ffff);
    send_request(MODE_PEEK_FRONT, 32'h0000_0000);
    send_request(MODE_PEEK_BACK, 32'h8000_0000);
    send_request(MODE_SPARE_6, 32'hffff_ffff);
    send_request(MODE_SPARE_7, 32'h0000_0000);
    send_request(MODE_PUSH_BACK, 32'h7fff_ffff);
    send_request(MODE_POP_BACK, 32'h0000_0000);
    send_request(MODE_PUSH_FRONT, 32'h8000_0000);
    send_request(MODE_PEEK_FRONT, 32'h0000_0000);
    send_request(MODE_PEEK_BACK, 32'h0000_0000);
    send_request(MODE_POP_FRONT, 32'hffff_ffff);
    send_request(MODE_PUSH_BACK, 32'h0000_0000);
    send_request(MODE_PUSH_FRONT, 32'hffff_ffff);
    send_request(MODE_PUSH_BACK, 32'h5555_5555);
    send_request(MODE_PUSH_FRONT, 32'haaaa_aaaa);
    send_request(MODE_SPARE_7, 32'h5555_5555);
    send_request(MODE_PEEK_BACK, 32'h0000_0000);
    send_request(MODE_POP_BACK, 32'haaaa_aaaa);
    send_request(MODE_POP_FRONT, 32'h5555_5555);
    send_request(MODE_POP_FRONT, 32'h0000_0000);
    send_request(MODE_POP_BACK, 32'h0000_0000);
    send_request(MODE_POP_BACK, 32'h0000_0000);
    @(negedge clk_i);
    req.valid <= 1'b0;
    wait_drained();

    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin
          send_idle_pct = 0;
          recv_stall_pct = 0;
          hold_request = 80;
        end
        1: begin
          send_idle_pct = 83;
          recv_stall_pct = 0;
        end
        2: begin
          send_idle_pct = 0;
          recv_stall_pct = 83;
        end
        default: begin
          send_idle_pct = 6;
          recv_stall_pct = 6;
        end
      endcase
      run_random(ITEMS_PER_PHASE);
      @(negedge clk_i);
      req.valid <= 1'b0;
      wait_drained();
    end

    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (shadow.mismatches == 0 && shadow.outstanding() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
